// ===== rtl/core/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// Used by every module in rtl/core by scoped name; depends on nothing.
`timescale 1ns / 1ps
package sem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int NSTAGE    = 10;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [0:0] OP_PIXEL         = 1'd0;
	localparam logic [0:0] OP_FLUSH         = 1'd1;

	typedef struct packed {
		logic [0:0] opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_edge;
		logic [7:0] green_edge;
		logic [7:0] blue_edge;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// cols[0] is the left column of the window
	typedef struct packed {
		col_t [2:0] cols;
		logic       last;
	} win_t;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ROWSTART,
		KIND_FINAL
	} kind_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] chan(input pix_t p, input logic [1:0] ch);
		logic [7:0] v;
		unique case (ch)
			2'd0:    v = p.r;
			2'd1:    v = p.g;
			default: v = p.b;
		endcase
		return v;
	endfunction

	function automatic logic signed [10:0] grad_x(input win_t w, input logic [1:0] ch);
		logic signed [11:0] pos;
		logic signed [11:0] neg;
		logic signed [11:0] d;
		pos = $signed({4'd0, chan(w.cols[2].top, ch)}) + $signed({3'd0, chan(w.cols[2].mid, ch), 1'b0})
			+ $signed({4'd0, chan(w.cols[2].bot, ch)});
		neg = $signed({4'd0, chan(w.cols[0].top, ch)}) + $signed({3'd0, chan(w.cols[0].mid, ch), 1'b0})
			+ $signed({4'd0, chan(w.cols[0].bot, ch)});
		d = pos - neg;
		return d[10:0];
	endfunction

	function automatic logic signed [10:0] grad_y(input win_t w, input logic [1:0] ch);
		logic signed [11:0] pos;
		logic signed [11:0] neg;
		logic signed [11:0] d;
		pos = $signed({4'd0, chan(w.cols[0].bot, ch)}) + $signed({3'd0, chan(w.cols[1].bot, ch), 1'b0})
			+ $signed({4'd0, chan(w.cols[2].bot, ch)});
		neg = $signed({4'd0, chan(w.cols[0].top, ch)}) + $signed({3'd0, chan(w.cols[1].top, ch), 1'b0})
			+ $signed({4'd0, chan(w.cols[2].top, ch)});
		d = pos - neg;
		return d[10:0];
	endfunction

endpackage

// ===== rtl/core/sem_front.sv =====
// Front part: position counters, line stores and the 3x3 window.
// Depends on sem_pkg; pushes finished windows into sem_queue.
`timescale 1ns / 1ps
module sem_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [10:0]        image_width,
	input  logic [15:0]        image_height,
	input  logic               in_valid,
	output logic               in_stall,
	input  sem_pkg::in_item_t  in_data,
	input  logic               q_full,
	output logic               q_push,
	output sem_pkg::win_t      q_data
);

	// Effective frame size
	logic [10:0] eff_w;
	logic [15:0] eff_h;
	always_comb begin
		if (image_width == 11'd0) eff_w = 11'd1;
		else if (image_width > 11'(sem_pkg::MAX_WIDTH)) eff_w = 11'(sem_pkg::MAX_WIDTH);
		else eff_w = image_width;
		eff_h = (image_height == 16'd0) ? 16'd1 : image_height;
	end

	logic [sem_pkg::COL_W-1:0] col_q;
	logic [16:0]               row_q;

	logic                      v_s1;
	sem_pkg::kind_t            kind_s1;
	logic                      emit_s1;
	logic [sem_pkg::COL_W-1:0] addr_s1;
	logic                      ge1_s1;
	logic                      ge2_s1;
	logic                      fwd_s1;
	sem_pkg::pix_t             pix_s1;
	sem_pkg::pix_t             up_rd_s1;
	sem_pkg::pix_t             mid_rd_s1;
	sem_pkg::pix_t             wr_up_q;
	sem_pkg::pix_t             wr_mid_q;
	sem_pkg::col_t [2:0]       win_q;

	sem_pkg::pix_t             upper_mem [sem_pkg::MAX_WIDTH];
	sem_pkg::pix_t             middle_mem [sem_pkg::MAX_WIDTH];

	logic                      s1_fire;
	logic                      accept;
	logic                      act;
	logic                      drain;
	logic                      fin;
	logic [sem_pkg::COL_W-1:0] c;
	sem_pkg::kind_t            kind;
	logic                      emit;
	logic                      wr_en;
	sem_pkg::col_t             col;

	// Classify the incoming transaction
	always_comb begin
		s1_fire  = v_s1 && !(emit_s1 && q_full);
		in_stall = v_s1 && !s1_fire;
		accept   = in_valid && !in_stall;
		drain    = row_q >= {1'b0, eff_h};
		fin      = row_q >= ({1'b0, eff_h} + 17'd1);
		act      = accept && (drain || (in_data.opcode == sem_pkg::OP_PIXEL));
		if ({1'b0, col_q} >= eff_w) c = sem_pkg::COL_W'(eff_w - 11'd1);
		else c = col_q;
		if (fin) begin
			kind = sem_pkg::KIND_FINAL;
			emit = 1'b1;
		end else if (c == '0) begin
			kind = sem_pkg::KIND_ROWSTART;
			emit = row_q >= 17'd2;
		end else begin
			kind = sem_pkg::KIND_NORMAL;
			emit = row_q >= 17'd1;
		end
	end

	// Advance input position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (act) begin
			if (fin) begin
				col_q <= '0;
				row_q <= '0;
			end else if ({1'b0, c} + 11'd1 >= eff_w) begin
				col_q <= '0;
				row_q <= row_q + 17'd1;
			end else begin
				col_q <= c + 1'b1;
			end
		end
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (act) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage one payload; forward a write to the same column
	always_ff @(posedge clk) begin
		if (act) begin
			kind_s1 <= kind;
			emit_s1 <= emit;
			addr_s1 <= c;
			ge1_s1  <= row_q >= 17'd1;
			ge2_s1  <= row_q >= 17'd2;
			fwd_s1  <= v_s1 && (kind_s1 != sem_pkg::KIND_FINAL) && (addr_s1 == c);
			pix_s1  <= drain ? '0 : sem_pkg::pix_t'({in_data.red_in, in_data.green_in,
				in_data.blue_in});
		end
	end

	// Assemble the new column
	always_comb begin
		col.top = ge2_s1 ? (fwd_s1 ? wr_up_q : up_rd_s1) : '0;
		col.mid = ge1_s1 ? (fwd_s1 ? wr_mid_q : mid_rd_s1) : '0;
		col.bot = pix_s1;
		wr_en   = s1_fire && (kind_s1 != sem_pkg::KIND_FINAL);
	end

	// Line stores: read on accept, write back when stage one leaves
	always_ff @(posedge clk) begin
		if (act) up_rd_s1 <= upper_mem[c];
		if (wr_en) upper_mem[addr_s1] <= col.mid;
	end

	always_ff @(posedge clk) begin
		if (act) mid_rd_s1 <= middle_mem[c];
		if (wr_en) middle_mem[addr_s1] <= col.bot;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_up_q  <= col.mid;
			wr_mid_q <= col.bot;
		end
	end

	// Update the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_fire) begin
			unique case (kind_s1)
				sem_pkg::KIND_NORMAL:   win_q <= {col, win_q[2], win_q[1]};
				sem_pkg::KIND_ROWSTART: win_q <= {col, 48'd0, 24'd0, 48'd0, 24'd0};
				default:                win_q <= '0;
			endcase
		end
	end

	// Window handed to the back part
	always_comb begin
		q_push = s1_fire && emit_s1;
		q_data.last = kind_s1 == sem_pkg::KIND_FINAL;
		if (kind_s1 == sem_pkg::KIND_NORMAL) q_data.cols = {col, win_q[2], win_q[1]};
		else q_data.cols = {72'd0, win_q[2], win_q[1]};
	end

endmodule

// ===== rtl/core/sem_queue.sv =====
// Short queue of windows between the front and back parts.
// Depends on sem_pkg for the entry type and depth.
`timescale 1ns / 1ps
module sem_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sem_pkg::win_t     wdata,
	input  logic              pop,
	output sem_pkg::win_t     rdata,
	output sem_pkg::q_stat_t  stat
);

	sem_pkg::win_t                mem_q [sem_pkg::QDEPTH];
	logic [sem_pkg::QPTR_W-1:0]   wr_q;
	logic [sem_pkg::QPTR_W-1:0]   rd_q;
	logic [sem_pkg::QPTR_W:0]     cnt_q;
	logic                         do_push;
	logic                         do_pop;

	always_comb begin
		stat.full  = cnt_q == (sem_pkg::QPTR_W+1)'(sem_pkg::QDEPTH);
		stat.empty = cnt_q == '0;
		do_push    = push && !stat.full;
		do_pop     = pop && !stat.empty;
		stat.push  = push;
		stat.pop   = do_pop;
		rdata      = mem_q[rd_q];
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (sem_pkg::QPTR_W+1)'(do_push) - (sem_pkg::QPTR_W+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/core/sem_back.sv =====
// Back part: gradients, squared magnitude and a bit-per-stage rounded root.
// Depends on sem_pkg; drains sem_queue and drives the result channel.
`timescale 1ns / 1ps
module sem_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sem_pkg::win_t      q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output sem_pkg::out_item_t out_data
);

	localparam int N = sem_pkg::NSTAGE;

	logic [N:0]          adv;
	logic [N-1:0]        v_q;
	logic [N-1:0]        last_q;
	logic signed [10:0]  gx_s1 [3];
	logic signed [10:0]  gy_s1 [3];
	logic [20:0]         sum_q [1:N-1][3];
	logic [7:0]          root_q [1:N-1][3];
	logic                out_valid_q;
	sem_pkg::out_item_t  out_q;

	// Stage advance chain
	always_comb begin
		adv[N] = !out_valid_q || !out_stall;
		for (int k = N-1; k >= 0; k--) adv[k] = !v_q[k] || adv[k+1];
		q_pop = !q_empty && adv[0];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv[0]) v_q[0] <= q_pop;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) v_q[k] <= v_q[k-1];
			end
			if (adv[N]) out_valid_q <= v_q[N-1];
		end
	end

	// Gradient stage, squared magnitude stage, then root stages with one
	// result bit each, most significant first
	always_ff @(posedge clk) begin
		logic [7:0]  trial;
		logic [15:0] tsq;
		if (adv[0]) begin
			last_q[0] <= q_data.last;
			for (int ch = 0; ch < 3; ch++) begin
				gx_s1[ch] <= sem_pkg::grad_x(q_data, 2'(ch));
				gy_s1[ch] <= sem_pkg::grad_y(q_data, 2'(ch));
			end
		end
		if (adv[1]) begin
			last_q[1] <= last_q[0];
			for (int ch = 0; ch < 3; ch++) begin
				sum_q[1][ch]  <= 21'(gx_s1[ch] * gx_s1[ch]) + 21'(gy_s1[ch] * gy_s1[ch]);
				root_q[1][ch] <= '0;
			end
		end
		for (int k = 2; k < N; k++) begin
			if (adv[k]) begin
				last_q[k] <= last_q[k-1];
				for (int ch = 0; ch < 3; ch++) begin
					trial = root_q[k-1][ch] | (8'd1 << (N-1-k));
					tsq   = trial * trial;
					sum_q[k][ch]  <= sum_q[k-1][ch];
					root_q[k][ch] <= ({5'd0, tsq} <= sum_q[k-1][ch]) ? trial : root_q[k-1][ch];
				end
			end
		end
	end

	// Round, clamp and hold the result
	always_ff @(posedge clk) begin
		logic [16:0] thr;
		logic [8:0]  res [3];
		if (adv[N]) begin
			for (int ch = 0; ch < 3; ch++) begin
				thr = 17'(root_q[N-1][ch] * root_q[N-1][ch]) + 17'(root_q[N-1][ch]);
				res[ch] = (sum_q[N-1][ch] > {4'd0, thr}) ? {1'b0, root_q[N-1][ch]} + 9'd1
					: {1'b0, root_q[N-1][ch]};
			end
			out_q.red_edge   <= res[0][8] ? 8'd255 : res[0][7:0];
			out_q.green_edge <= res[1][8] ? 8'd255 : res[1][7:0];
			out_q.blue_edge  <= res[2][8] ? 8'd255 : res[2][7:0];
			out_q.frame_end  <= last_q[N-1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/sobel_edge_magnitude_top.sv =====
// Top level of the streaming RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries pixels of one frame in
//    raster order (opcode pixel) and, after the frame, flush transactions.
//  - After the last pixel send image_width+1 flush transactions (width
//    clamped to 1..1024); the last result of the frame carries frame_end.
//  - A result belongs to the pixel one row plus one pixel back.
//  - Throughput: one transaction per cycle while in_stall is low. The front
//    stage reads the line stores on accept and writes them back as it leaves.
//  - Path from the accepting edge of the causing transaction to the result
//    on out_data: front stage, queue, then the back stages ending in the
//    output register.
//  - When the receiver stalls, the result register holds, the back stages
//    fill, the four-entry queue fills, then in_stall rises.
//  - Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data is always
//    ready; write it only while the block is idle.
//  - Reset clears counters, window and handshakes; width 640, height 480.
//    The line stores are not cleared; their contents are only used after being written.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sem_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sem_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [10:0]      image_width_q;
	logic [15:0]      image_height_q;
	logic             q_push;
	logic             q_pop;
	sem_pkg::win_t    q_wdata;
	sem_pkg::win_t    q_rdata;
	sem_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd640;
			image_height_q <= 16'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sem_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[10:0];
				sem_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sem_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.q_full       (q_stat.full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	sem_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	sem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.push |-> !q_stat.full)
		else $error("window pushed into full queue");

	// Queue cannot be full and empty at once
	a_q_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// A pop only happens with data present
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// Input stalls only while the front stage is blocked by a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled without full queue");

endmodule
